>>> src/pvd_pkg.sv
// Shared types, constants and arithmetic helpers for the voxel density core.
`timescale 1ns / 1ps
package pvd_pkg;

    typedef enum logic [1:0] {
        MODE_SPHERE  = 2'd0,
        MODE_SHELLS  = 2'd1,
        MODE_GYROID  = 2'd2,
        MODE_UNKNOWN = 2'd3
    } mode_t;

    localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
    localparam logic signed [31:0] SIN_C3 = -32'sd693598668;
    localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
    localparam logic signed [31:0] SIN_C7 = -32'sd5026995;
    localparam logic signed [31:0] SIN_C9 = 32'sd172272;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565275;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    // Signed 64-bit product divided by 2^30, truncated toward zero.
    function automatic logic signed [63:0] q30_div(input logic signed [63:0] p);
        logic signed [63:0] adj;
        begin
            adj = p + ((p < 0) ? 64'sd1073741823 : 64'sd0);
            q30_div = adj >>> 30;
        end
    endfunction

endpackage

>>> src/pvd_stream_if.sv
// Valid/ready stream interface with a generic payload.
`timescale 1ns / 1ps
interface pvd_stream_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/pvd_sine.sv
// Pipelined Q30 sine of a 32-bit phase, degree-9 odd polynomial, with enable.
`timescale 1ns / 1ps
module pvd_sine
    import pvd_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         phase,
    output logic signed [31:0]  sine
);

    logic [1:0]          quad_reg [0:5];
    logic signed [31:0]  u_reg [0:6];
    logic signed [31:0]  w_reg [1:4];
    logic signed [31:0]  t_reg [1:5];

    logic [29:0]         frac;
    logic signed [31:0]  u_next;
    logic signed [63:0]  w_full;
    logic signed [63:0]  t_step [2:5];
    logic signed [63:0]  y_full;
    logic signed [31:0]  y_clamp;

    assign frac   = phase[29:0];
    assign u_next = phase[30] ? (Q30_ONE - $signed({2'b00, frac}))
                              : $signed({2'b00, frac});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= phase[31:30];
            u_reg[0]    <= u_next;
        end
    end

    assign w_full = q30_div(64'(u_reg[0]) * 64'(u_reg[0]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[1] <= quad_reg[0];
            u_reg[1]    <= u_reg[0];
            w_reg[1]    <= w_full[31:0];
            t_reg[1]    <= SIN_C9;
        end
    end

    assign t_step[2] = 64'(SIN_C7) + q30_div(64'(t_reg[1]) * 64'(w_reg[1]));
    assign t_step[3] = 64'(SIN_C5) + q30_div(64'(t_reg[2]) * 64'(w_reg[2]));
    assign t_step[4] = 64'(SIN_C3) + q30_div(64'(t_reg[3]) * 64'(w_reg[3]));
    assign t_step[5] = 64'(SIN_C1) + q30_div(64'(t_reg[4]) * 64'(w_reg[4]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 2; i <= 5; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
                u_reg[i]    <= u_reg[i-1];
                t_reg[i]    <= t_step[i][31:0];
            end
            for (int i = 2; i <= 4; i++)
                w_reg[i] <= w_reg[i-1];
        end
    end

    assign y_full  = q30_div(64'(t_reg[5]) * 64'(u_reg[5]));
    assign y_clamp = (y_full < 0) ? 32'sd0 : ((y_full > 64'(Q30_ONE)) ? Q30_ONE : y_full[31:0]);

    always_ff @(posedge clk)
    begin
        if (en)
            u_reg[6] <= quad_reg[5][1] ? -y_clamp : y_clamp;
    end

    assign sine = u_reg[6];

endmodule

>>> src/pvd_isqrt.sv
// Pipelined integer square root, two result bits per stage.
`timescale 1ns / 1ps
module pvd_isqrt #(
    parameter int IN_W = 48
) (
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     value,
    output logic [IN_W/2-1:0]   root
);
    localparam int STEPS = IN_W / 2;
    localparam int PER   = 2;
    localparam int NST   = (STEPS + PER - 1) / PER;

    logic [IN_W-1:0]   rem_reg  [0:NST];
    logic [IN_W/2-1:0] res_reg  [0:NST];
    logic [IN_W-1:0]   rem_c    [0:NST-1][0:PER];
    logic [IN_W/2-1:0] res_c    [0:NST-1][0:PER];

    always_comb
    begin
        for (int s = 0; s < NST; s++)
        begin
            rem_c[s][0] = rem_reg[s];
            res_c[s][0] = res_reg[s];
            for (int k = 0; k < PER; k++)
            begin
                if (s * PER + k < STEPS)
                begin
                    logic [IN_W+1:0] trial;
                    logic [IN_W+1:0] remx;
                    int b;
                    b     = STEPS - 1 - (s * PER + k);
                    remx  = {2'b00, rem_c[s][k]};
                    trial = ({2'b00, {(IN_W/2){1'b0}}, res_c[s][k]} << (b + 1))
                          | ((IN_W+2)'(1) << (2 * b));
                    if (remx >= trial)
                    begin
                        rem_c[s][k+1] = IN_W'(remx - trial);
                        res_c[s][k+1] = res_c[s][k] | ((IN_W/2)'(1) << b);
                    end
                    else
                    begin
                        rem_c[s][k+1] = rem_c[s][k];
                        res_c[s][k+1] = res_c[s][k];
                    end
                end
                else
                begin
                    rem_c[s][k+1] = rem_c[s][k];
                    res_c[s][k+1] = res_c[s][k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= value;
            res_reg[0] <= '0;
            for (int s = 0; s < NST; s++)
            begin
                rem_reg[s+1] <= rem_c[s][PER];
                res_reg[s+1] <= res_c[s][PER];
            end
        end
    end

    assign root = res_reg[NST];

endmodule

>>> src/procedural_voxel_density_core.sv
// Top level of the procedural voxel density core.
`timescale 1ns / 1ps
// Takes one signed Q2.14 coordinate triple per clock and returns one density byte
// for the pattern in the mode register (sphere, sine shells, gyroid, or zero).
// The datapath is a fixed-depth pipeline: a pipelined square root and seven
// pipelined polynomial sine units, followed by product and scaling stages, so the
// sustained rate is one item per cycle while density_out is ready. The result of
// an item passes through two input stages, twelve square root stages, one phase
// stage, seven sine stages, the post stages A and B and the output register. A
// waiting output that is not taken freezes the whole pipeline.
module procedural_voxel_density_core
    import pvd_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    pvd_stream_if.sink   coord_in,
    pvd_stream_if.source density_out
);
    localparam int RAD_BITS = FRAC_BITS + 4;
    localparam int R2_W     = 34;
    localparam int SQ_IN_W  = 2 * ((R2_W + 8 + 1) / 2);
    localparam int ROOT_W   = SQ_IN_W / 2;
    localparam int SQ_NST   = (ROOT_W + 1) / 2;
    localparam int SIN_LAT  = 7;
    localparam int LAT      = 2 + SQ_NST + 1 + SIN_LAT + 3;

    mode_t mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SPHERE;
        else if (cfg_we)
            mode_reg <= mode_t'(cfg_wdata);
    end

    logic en;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg;
    logic [7:0] out_data_reg;

    assign en = !(out_valid_reg && !density_out.ready);
    assign coord_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], coord_in.valid};
    end

    logic signed [15:0] cx, cy, cz;
    assign cx = coord_in.data[15:0];
    assign cy = coord_in.data[31:16];
    assign cz = coord_in.data[47:32];

    // stage 0: squares, gyroid phases
    logic [31:0] sqx_reg, sqy_reg, sqz_reg;
    logic [31:0] ph_reg [0:5];
    mode_t m0_reg;

    function automatic logic [31:0] gphase(input logic signed [15:0] c);
        logic [31:0] t;
        begin
            t = 32'(32'sd3 * 32'(c));
            gphase = t << (31 - FRAC_BITS);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= 32'(32'(cx) * 32'(cx));
            sqy_reg  <= 32'(32'(cy) * 32'(cy));
            sqz_reg  <= 32'(32'(cz) * 32'(cz));
            ph_reg[0] <= gphase(cx);
            ph_reg[1] <= gphase(cx) + QUARTER_TURN;
            ph_reg[2] <= gphase(cy);
            ph_reg[3] <= gphase(cy) + QUARTER_TURN;
            ph_reg[4] <= gphase(cz);
            ph_reg[5] <= gphase(cz) + QUARTER_TURN;
            m0_reg   <= mode_reg;
        end
    end

    // stage 1: radius squared and range tests
    logic [R2_W-1:0] r2;
    logic in08, in09;
    assign r2   = R2_W'(sqx_reg) + R2_W'(sqy_reg) + R2_W'(sqz_reg);
    assign in08 = (64'(r2) * 64'd25) < (64'd16 << (2 * FRAC_BITS));
    assign in09 = (64'(r2) * 64'd100) < (64'd81 << (2 * FRAC_BITS));

    logic [R2_W-1:0] r2_reg;
    logic [31:0] ph1_reg [0:5];
    logic in08_reg, in09_reg;
    mode_t m1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg   <= r2;
            ph1_reg  <= ph_reg;
            in08_reg <= in08;
            in09_reg <= in09;
            m1_reg   <= m0_reg;
        end
    end

    logic [ROOT_W-1:0] root;
    pvd_isqrt #(.IN_W(SQ_IN_W)) u_isqrt (
        .clk   (clk),
        .en    (en),
        .value (SQ_IN_W'({r2_reg, 8'd0})),
        .root  (root)
    );

    logic [31:0] phd_reg [0:SQ_NST][0:5];
    logic in08_d [0:SQ_NST];
    logic in09_d [0:SQ_NST];
    mode_t md [0:SQ_NST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phd_reg[0] <= ph1_reg;
            in08_d[0]  <= in08_reg;
            in09_d[0]  <= in09_reg;
            md[0]      <= m1_reg;
            for (int i = 1; i <= SQ_NST; i++)
            begin
                phd_reg[i] <= phd_reg[i-1];
                in08_d[i]  <= in08_d[i-1];
                in09_d[i]  <= in09_d[i-1];
                md[i]      <= md[i-1];
            end
        end
    end

    // stage: shell phase, sphere density
    logic [63:0] shell_prod;
    logic [31:0] shell_ph;
    logic [63:0] sph_num;
    logic [63:0] sph_d;
    assign shell_prod = (64'(root) * 64'd40) * 64'(INV_TWO_PI_Q32);
    assign shell_ph   = 32'(shell_prod >> RAD_BITS);
    assign sph_num    = (64'd4 << RAD_BITS) - 64'(root) * 64'd5;
    assign sph_d      = (64'd255 * sph_num) >> (RAD_BITS + 2);

    logic [31:0] sph_in [0:6];
    logic [7:0] sphd_reg;
    logic in08_s, in09_s;
    mode_t ms;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
                sph_in[i] <= phd_reg[SQ_NST][i];
            sph_in[6] <= shell_ph;
            sphd_reg  <= (sph_d > 64'd255) ? 8'd255 : sph_d[7:0];
            in08_s    <= in08_d[SQ_NST];
            in09_s    <= in09_d[SQ_NST];
            ms        <= md[SQ_NST];
        end
    end

    logic signed [31:0] sv [0:6];
    for (genvar g = 0; g < 7; g++)
    begin : g_sin
        pvd_sine u_sine (
            .clk   (clk),
            .en    (en),
            .phase (sph_in[g]),
            .sine  (sv[g])
        );
    end

    logic [7:0] sphd_d [0:SIN_LAT-1];
    logic in08_e [0:SIN_LAT-1];
    logic in09_e [0:SIN_LAT-1];
    mode_t me [0:SIN_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sphd_d[0] <= sphd_reg;
            in08_e[0] <= in08_s;
            in09_e[0] <= in09_s;
            me[0]     <= ms;
            for (int i = 1; i < SIN_LAT; i++)
            begin
                sphd_d[i] <= sphd_d[i-1];
                in08_e[i] <= in08_e[i-1];
                in09_e[i] <= in09_e[i-1];
                me[i]     <= me[i-1];
            end
        end
    end

    // post stage A: products
    logic signed [63:0] s_half;
    assign s_half = (64'(Q30_ONE) + 64'(sv[6])) >>> 1;

    logic signed [63:0] pa_reg, pb_reg, pc_reg, ss_reg;
    logic [7:0] sphd_a;
    logic in08_a, in09_a;
    mode_t ma;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= q30_div(64'(sv[0]) * 64'(sv[3]));
            pb_reg <= q30_div(64'(sv[2]) * 64'(sv[5]));
            pc_reg <= q30_div(64'(sv[4]) * 64'(sv[1]));
            ss_reg <= q30_div(s_half * s_half);
            sphd_a <= sphd_d[SIN_LAT-1];
            in08_a <= in08_e[SIN_LAT-1];
            in09_a <= in09_e[SIN_LAT-1];
            ma     <= me[SIN_LAT-1];
        end
    end

    // post stage B: gyroid sum, shell scale
    logic signed [63:0] gsum, gabs;
    assign gsum = pa_reg + pb_reg + pc_reg;
    assign gabs = (gsum < 0) ? -gsum : gsum;

    logic [63:0] shd_w;
    logic [63:0] gd_w;
    logic gin;
    assign shd_w = (64'd255 * 64'(ss_reg)) >> 30;
    assign gin   = (gabs * 64'sd10) < (64'sd3 * 64'(Q30_ONE));
    assign gd_w  = 64'((64'sd85 * (64'sd3 * 64'(Q30_ONE) - 64'sd10 * gabs)) >>> 30);

    logic [7:0] dens_next;
    always_comb
    begin
        dens_next = 8'd0;
        unique case (ma)
            MODE_SPHERE:  dens_next = in08_a ? sphd_a : 8'd0;
            MODE_SHELLS:  dens_next = in09_a ? ((shd_w > 64'd255) ? 8'd255 : shd_w[7:0]) : 8'd0;
            MODE_GYROID:  dens_next = gin ? ((gd_w > 64'd255) ? 8'd255 : gd_w[7:0]) : 8'd0;
            MODE_UNKNOWN: dens_next = 8'd0;
            default:      dens_next = 8'd0;
        endcase
    end

    logic [7:0] dens_b;
    always_ff @(posedge clk)
    begin
        if (en)
            dens_b <= dens_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[LAT-1];
        else if (density_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= dens_b;
    end

    assign density_out.valid = out_valid_reg;
    assign density_out.data  = out_data_reg;

endmodule

>>> test/voxel_density_checker.sv
// Checker for the voxel density core: predicts each density byte and compares it.
`timescale 1ns / 1ps
module voxel_density_checker
    import pvd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    pvd_stream_if      coord_mon,
    pvd_stream_if      density_mon,
    output int         fail_count,
    output int         pending
);

    localparam longint ONE_Q30 = 64'sd1 << 30;

    mode_t             cur_mode;
    logic [7:0]        density_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitpos;
        v = v_in;
        res = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= res + bitpos)
            begin
                v = v - (res + bitpos);
                res = (res >> 1) + bitpos;
            end
            else
            begin
                res = res >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return res;
    endfunction

    function automatic longint sine_q30(input logic [31:0] ph);
        logic [1:0] quad;
        longint     f;
        longint     u;
        longint     w;
        longint     t;
        longint     y;
        quad = ph[31:30];
        f = longint'({34'd0, ph[29:0]});
        u = quad[0] ? (ONE_Q30 - f) : f;
        w = (u * u) / ONE_Q30;
        t = longint'(SIN_C9);
        t = longint'(SIN_C7) + (t * w) / ONE_Q30;
        t = longint'(SIN_C5) + (t * w) / ONE_Q30;
        t = longint'(SIN_C3) + (t * w) / ONE_Q30;
        t = longint'(SIN_C1) + (t * w) / ONE_Q30;
        y = (t * u) / ONE_Q30;
        if (y < 0)
            y = 0;
        if (y > ONE_Q30)
            y = ONE_Q30;
        return quad[1] ? -y : y;
    endfunction

    function automatic logic [31:0] gyroid_turns(input logic signed [15:0] c);
        logic [31:0] t;
        t = 32'(3 * int'(c));
        return t << 17;
    endfunction

    function automatic logic [7:0] voxel_density(input mode_t m, input logic signed [15:0] x,
                                                 input logic signed [15:0] y,
                                                 input logic signed [15:0] z);
        longint          xs;
        longint          ys;
        longint          zs;
        longint unsigned r2;
        longint unsigned one2;
        longint unsigned r;
        longint unsigned dens;
        logic [31:0]     ph;
        logic [31:0]     px;
        logic [31:0]     py;
        logic [31:0]     pz;
        longint          s;
        longint          s2;
        longint          g;
        longint          ag;
        xs = x;
        ys = y;
        zs = z;
        r2 = xs * xs + ys * ys + zs * zs;
        one2 = 64'd1 << 28;
        dens = 0;
        case (m)
            MODE_SPHERE:
            begin
                if (25 * r2 < 16 * one2)
                begin
                    r = int_sqrt(r2 << 8);
                    dens = (64'd255 * ((64'd4 << 18) - 64'd5 * r)) >> 20;
                end
            end
            MODE_SHELLS:
            begin
                if (100 * r2 < 81 * one2)
                begin
                    r = int_sqrt(r2 << 8);
                    ph = 32'((64'd40 * r * 64'd683565275) >> 18);
                    s = (ONE_Q30 + sine_q30(ph)) / 2;
                    s2 = (s * s) / ONE_Q30;
                    dens = longint'((255 * s2) / ONE_Q30);
                end
            end
            MODE_GYROID:
            begin
                px = gyroid_turns(x);
                py = gyroid_turns(y);
                pz = gyroid_turns(z);
                g = (sine_q30(px) * sine_q30(py + QUARTER_TURN)) / ONE_Q30
                  + (sine_q30(py) * sine_q30(pz + QUARTER_TURN)) / ONE_Q30
                  + (sine_q30(pz) * sine_q30(px + QUARTER_TURN)) / ONE_Q30;
                ag = (g < 0) ? -g : g;
                if (10 * ag < 3 * ONE_Q30)
                    dens = longint'((85 * (3 * ONE_Q30 - 10 * ag)) / ONE_Q30);
            end
            default:
                dens = 0;
        endcase
        if (dens > 255)
            dens = 255;
        return dens[7:0];
    endfunction

    assign pending = density_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode <= MODE_SPHERE;
            fail_count <= 0;
            density_q.delete();
        end
        else
        begin
            if (cfg_we)
                cur_mode <= mode_t'(cfg_wdata);
            if (coord_mon.valid && coord_mon.ready)
                density_q.push_back(voxel_density(cur_mode, coord_mon.data[15:0],
                                                  coord_mon.data[31:16],
                                                  coord_mon.data[47:32]));
            if (density_mon.valid && density_mon.ready)
            begin
                if (density_q.size() == 0)
                begin
                    $error("density: unexpected item, actual %0d", density_mon.data);
                    fail_count <= fail_count + 1;
                end
                else if (density_mon.data !== density_q[0])
                begin
                    $error("density: expected %0d actual %0d", density_q[0], density_mon.data);
                    fail_count <= fail_count + 1;
                    void'(density_q.pop_front());
                end
                else
                begin
                    void'(density_q.pop_front());
                end
            end
        end
    end

endmodule

>>> test/tb_procedural_voxel_density_core.sv
// Testbench top for the voxel density core: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module tb_procedural_voxel_density_core;
    import pvd_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    int         fail_count;
    int         pending;

    pvd_stream_if #(.WIDTH(48)) coord_if ();
    pvd_stream_if #(.WIDTH(8))  density_if ();

    procedural_voxel_density_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .coord_in    (coord_if.sink),
        .density_out (density_if.source)
    );

    voxel_density_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .coord_mon   (coord_if),
        .density_mon (density_if),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7)
            return 16'($urandom_range(0, 32768) - 16384);
        else if (p < 9)
            return 16'($urandom_range(0, 26000) - 13000);
        else
            return 16'($urandom);
    endfunction

    task automatic send_voxel(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        int gap;
        coord_if.data <= {z, y, x};
        coord_if.valid <= 1'b1;
        @(posedge clk);
        while (!coord_if.ready)
            @(posedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            coord_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_mode(input mode_t m);
        coord_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_set();
        send_voxel(16'sd0, 16'sd0, 16'sd0);
        send_voxel(16'sd16384, 16'sd0, 16'sd0);
        send_voxel(-16'sd16384, -16'sd16384, -16'sd16384);
        send_voxel(16'sh8000, 16'sh7fff, 16'sh8000);
        send_voxel(16'sd13107, 16'sd0, 16'sd0);
        send_voxel(16'sd13108, 16'sd0, 16'sd0);
        send_voxel(16'sd0, 16'sd14745, 16'sd0);
        send_voxel(16'sd0, 16'sd0, 16'sd14746);
        send_voxel(16'sh5555, 16'shaaaa, 16'sh1234);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            density_if.ready <= 1'b0;
        else
            density_if.ready <= ($urandom_range(0, 99) < 70);
    end

    initial
    begin
        mode_t modes[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        coord_if.valid = 1'b0;
        coord_if.data = '0;
        modes = '{MODE_SPHERE, MODE_SHELLS, MODE_GYROID, MODE_UNKNOWN, MODE_GYROID, MODE_SPHERE};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (modes[i])
        begin
            set_mode(modes[i]);
            if (i < 3)
                directed_set();
            repeat (80)
                send_voxel(rand_coord(), rand_coord(), rand_coord());
        end
        coord_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASS procedural_voxel_density_core");
        else
            $display("FAIL procedural_voxel_density_core");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL procedural_voxel_density_core");
        $finish;
    end

endmodule

>>> procedural_voxel_density_core.f
src/pvd_pkg.sv
src/pvd_stream_if.sv
src/pvd_sine.sv
src/pvd_isqrt.sv
src/procedural_voxel_density_core.sv
test/voxel_density_checker.sv
test/tb_procedural_voxel_density_core.sv
